// ===== sv/srect_pkg.sv =====
// Shared types, widths and helpers for the segment/rectangle intersection pipeline.
// No dependencies; imported by every stage module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package srect_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 2;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    localparam int SIDE_LEFT   = 0;
    localparam int SIDE_RIGHT  = 1;
    localparam int SIDE_TOP    = 2;
    localparam int SIDE_BOTTOM = 3;
    localparam int SIDES       = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    typedef struct packed {
        coord_t                  sx;
        coord_t                  sy;
        coord_t                  ex;
        coord_t                  ey;
        coord_t                  rx;
        coord_t                  ry;
        logic [COORD_BITS-1:0]   rw;
        logic [COORD_BITS-1:0]   rh;
    } query_t;

    typedef struct packed {
        diff_t dx;
        diff_t dy;
        diff_t ax0;
        diff_t ax1;
        diff_t ay0;
        diff_t ay1;
        diff_t rw;
        diff_t rh;
    } delta_t;

    typedef struct packed {
        prod_t den_v;
        prod_t den_h;
        prod_t ra0;
        prod_t ra1;
        prod_t wa0;
        prod_t wa1;
        prod_t xa0;
        prod_t xa1;
        prod_t ya0;
        prod_t ya1;
    } term_t;

    typedef struct packed {
        sum_t [SIDES-1:0] den;
        sum_t [SIDES-1:0] na;
        sum_t [SIDES-1:0] nb;
    } frac_t;

    function automatic logic in_unit(input sum_t num, input sum_t den);
        logic res;
        if (den > 0)
        begin
            res = (num >= 0) && (num <= den);
        end
        else
        begin
            res = (num <= 0) && (num >= den);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/segment_rect_intersection.sv =====
// Segment versus axis-aligned rectangle edge test, four-stage pipeline.
// Depends on srect_pkg, srect_delta, srect_prod, srect_frac, srect_test.
//
// Accepts one item per clock while the output is not stalled and returns one result per
// item, in order, from the fourth stage register. Stage one forms coordinate
// differences, stage two runs the ten (COORD_BITS+2)-bit signed multipliers, stage three
// builds each edge's numerators and denominator, and stage four range-checks both
// parameters and registers the side mask. Each stage stalls only while its own result is
// held, so back-pressure bubbles collapse. Parallel or collinear edges never report a hit,
// and a segment wholly inside the rectangle reports none.
`timescale 1ns / 1ps
`default_nettype none

module segment_rect_intersection (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] seg_start_x,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] seg_start_y,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] seg_end_x,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] seg_end_y,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] rect_x,
    input  wire logic signed [srect_pkg::COORD_BITS-1:0] rect_y,
    input  wire logic        [srect_pkg::COORD_BITS-1:0] rect_w,
    input  wire logic        [srect_pkg::COORD_BITS-1:0] rect_h,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             hit,
    output logic [srect_pkg::SIDES-1:0]      side_mask
);
    import srect_pkg::*;

    query_t query;
    delta_t delta;
    term_t  term;
    frac_t  frac;
    logic   delta_valid;
    logic   delta_ready;
    logic   term_valid;
    logic   term_ready;
    logic   frac_valid;
    logic   frac_ready;

    always_comb
    begin
        query.sx = seg_start_x;
        query.sy = seg_start_y;
        query.ex = seg_end_x;
        query.ey = seg_end_y;
        query.rx = rect_x;
        query.ry = rect_y;
        query.rw = rect_w;
        query.rh = rect_h;
    end

    srect_delta u_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (query),
        .out_valid (delta_valid),
        .out_ready (delta_ready),
        .out_data  (delta)
    );

    srect_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (delta_valid),
        .in_ready  (delta_ready),
        .in_data   (delta),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_data  (term)
    );

    srect_frac u_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_valid),
        .in_ready  (term_ready),
        .in_data   (term),
        .out_valid (frac_valid),
        .out_ready (frac_ready),
        .out_data  (frac)
    );

    srect_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (frac_valid),
        .in_ready  (frac_ready),
        .in_data   (frac),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_mask  (side_mask)
    );

    assign hit = |side_mask;

endmodule

`default_nettype wire

// ===== sv/srect_delta.sv =====
// Stage 1: coordinate differences against the segment start and rectangle edges.
// Depends on srect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srect_delta (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire srect_pkg::query_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output srect_pkg::delta_t      out_data
);
    import srect_pkg::*;

    logic   valid_reg;
    delta_t data_reg;
    delta_t data_next;
    diff_t  sx;
    diff_t  sy;
    diff_t  rx;
    diff_t  ry;
    diff_t  rx2;
    diff_t  ry2;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        sx  = DIFF_BITS'(in_data.sx);
        sy  = DIFF_BITS'(in_data.sy);
        rx  = DIFF_BITS'(in_data.rx);
        ry  = DIFF_BITS'(in_data.ry);
        data_next.rw  = diff_t'({2'b00, in_data.rw});
        data_next.rh  = diff_t'({2'b00, in_data.rh});
        rx2 = rx + data_next.rw;
        ry2 = ry + data_next.rh;
        data_next.dx  = DIFF_BITS'(in_data.ex) - sx;
        data_next.dy  = DIFF_BITS'(in_data.ey) - sy;
        data_next.ax0 = sx - rx;
        data_next.ax1 = sx - rx2;
        data_next.ay0 = sy - ry;
        data_next.ay1 = sy - ry2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/srect_prod.sv =====
// Stage 2: the ten multiplier products for the edge tests of all four sides; some are shared between edges.
// Depends on srect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srect_prod (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire srect_pkg::delta_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output srect_pkg::term_t       out_data
);
    import srect_pkg::*;

    logic  valid_reg;
    term_t data_reg;
    term_t data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.den_v = in_data.rh * in_data.dx;
        data_next.den_h = in_data.rw * in_data.dy;
        data_next.ra0   = in_data.rh * in_data.ax0;
        data_next.ra1   = in_data.rh * in_data.ax1;
        data_next.wa0   = in_data.rw * in_data.ay0;
        data_next.wa1   = in_data.rw * in_data.ay1;
        data_next.xa0   = in_data.dx * in_data.ay0;
        data_next.xa1   = in_data.dx * in_data.ay1;
        data_next.ya0   = in_data.dy * in_data.ax0;
        data_next.ya1   = in_data.dy * in_data.ax1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    property p_den_zero;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=>
            ((data_reg.den_v == '0) ==
             ($past(in_data.rh) == '0 || $past(in_data.dx) == '0));
    endproperty
    a_den_zero: assert property (p_den_zero)
        else $error("vertical edge denominator zero flag mismatch");

endmodule

`default_nettype wire

// ===== sv/srect_frac.sv =====
// Stage 3: per-edge denominators and parametric numerators.
// Depends on srect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srect_frac (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire srect_pkg::term_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srect_pkg::frac_t      out_data
);
    import srect_pkg::*;

    logic  valid_reg;
    frac_t data_reg;
    frac_t data_next;
    sum_t  den_v;
    sum_t  den_h;
    sum_t  nb_lt;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        den_v = SUM_BITS'(in_data.den_v);
        den_h = -SUM_BITS'(in_data.den_h);
        nb_lt = SUM_BITS'(in_data.xa0) - SUM_BITS'(in_data.ya0);

        data_next.den[SIDE_LEFT]   = den_v;
        data_next.den[SIDE_RIGHT]  = den_v;
        data_next.den[SIDE_TOP]    = den_h;
        data_next.den[SIDE_BOTTOM] = den_h;

        data_next.na[SIDE_LEFT]    = -SUM_BITS'(in_data.ra0);
        data_next.na[SIDE_RIGHT]   = -SUM_BITS'(in_data.ra1);
        data_next.na[SIDE_TOP]     = SUM_BITS'(in_data.wa0);
        data_next.na[SIDE_BOTTOM]  = SUM_BITS'(in_data.wa1);

        data_next.nb[SIDE_LEFT]    = nb_lt;
        data_next.nb[SIDE_RIGHT]   = SUM_BITS'(in_data.xa0) - SUM_BITS'(in_data.ya1);
        data_next.nb[SIDE_TOP]     = nb_lt;
        data_next.nb[SIDE_BOTTOM]  = SUM_BITS'(in_data.xa1) - SUM_BITS'(in_data.ya0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/srect_test.sv =====
// Stage 4: range tests of both parameters per edge; holds the side mask output register.
// Depends on srect_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srect_test (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire srect_pkg::frac_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [srect_pkg::SIDES-1:0] out_mask
);
    import srect_pkg::*;

    logic             valid_reg;
    logic [SIDES-1:0] mask_reg;
    logic [SIDES-1:0] mask_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_mask  = mask_reg;

    always_comb
    begin
        for (int i = 0; i < SIDES; i++)
        begin
            mask_next[i] = (in_data.den[i] != '0)
                        && in_unit(in_data.na[i], in_data.den[i])
                        && in_unit(in_data.nb[i], in_data.den[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mask_reg <= mask_next;
        end
    end

    property p_vert_parallel;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.den[SIDE_LEFT] == '0) |=>
            (!mask_reg[SIDE_LEFT] && !mask_reg[SIDE_RIGHT]);
    endproperty
    a_vert_parallel: assert property (p_vert_parallel)
        else $error("vertical edge hit with zero denominator");

    property p_horz_parallel;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.den[SIDE_TOP] == '0) |=>
            (!mask_reg[SIDE_TOP] && !mask_reg[SIDE_BOTTOM]);
    endproperty
    a_horz_parallel: assert property (p_horz_parallel)
        else $error("horizontal edge hit with zero denominator");

    property p_hold_stalled;
        @(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(mask_reg));
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("stalled result changed");

endmodule

`default_nettype wire
